// File: rtl/core/gdfs_pkg.sv
`default_nettype none

package gdfs_pkg;

  // Fixed widths of the block's fields.
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned VERTEX_W = 6;
  localparam int unsigned ROW_W    = 64;

  // Default graph size and reset value of the vertex count register.
  localparam int unsigned VERTICES_DEF = 32;
  localparam logic [CNT_W-1:0] VCOUNT_RST = 7'd32;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_VTX,
    ST_ROW,
    ST_SCAN
  } st_e;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                status;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/graph_dfs_traversal.sv
// Channel    | Signals                                            | Transfer
// -----------+----------------------------------------------------+---------------------------
// item in    | start, kind_i, row_index_i, row_bits_i,            | start high, busy low
//            | start_vertex_i                                     |
// result out | result_valid_o, visited_vertex_o, status_o, last_o | result_valid_o high
// config     | cfg_we_i, cfg_wdata_i (vertex_count)               | cfg_we_i high
//
// A load item, or a start whose vertex is out of range, leaves busy low.
// A start item holds busy high until the traversal ends: each popped vertex passes through
// the stack pop, stack read and row read states (ST_POP, ST_VTX, ST_ROW), then the single
// shift-and-test scan unit tests one row bit per cycle below n, the effective vertex count.
// Reset clears the sequencer, stack pointer, visited map and vertex_count (to 32).
// Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none

module graph_dfs_traversal
  import gdfs_pkg::*;
#(
  parameter int unsigned VERTICES = VERTICES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic                kind_i,
  input  wire logic [5:0]          row_index_i,
  input  wire logic [ROW_W-1:0]    row_bits_i,
  input  wire logic [5:0]          start_vertex_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CNT_W-1:0]    cfg_wdata_i,
  output      logic                result_valid_o,
  output      logic [VERTEX_W-1:0] visited_vertex_o,
  output      logic                status_o,
  output      logic                last_o
);

  localparam int unsigned VW = $clog2(VERTICES);

  logic [CNT_W-1:0] vcount_q;
  logic [CNT_W-1:0] n_eff;
  logic             accept;
  logic             load_we;
  logic             go;
  logic             err;
  logic             stk_we;
  logic [VW-1:0]    stk_waddr, stk_wdata, stk_raddr, stk_rdata, adj_raddr;
  logic [VERTICES-1:0] adj_rdata;
  result_t          res;

  // The vertex count register. The user must change it only while idle; unchecked here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // Counts above the graph size saturate to the graph size.
  assign n_eff = (vcount_q > CNT_W'(VERTICES)) ? CNT_W'(VERTICES) : vcount_q;

  assign accept = start && !busy;

  // Rows for vertices beyond the graph size are dropped, as are row bits above it.
  assign load_we = accept && (kind_i == KIND_LOAD) &&
                   ({1'b0, row_index_i} < CNT_W'(VERTICES));

  // A start vertex at or above the effective count gives a single error result.
  assign go  = accept && (kind_i == KIND_START) && ({1'b0, start_vertex_i} < n_eff);
  assign err = accept && (kind_i == KIND_START) && !({1'b0, start_vertex_i} < n_eff);

  gdfs_ram #(
    .WIDTH (VERTICES),
    .DEPTH (VERTICES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (row_index_i[VW-1:0]),
    .wdata_i (row_bits_i[VERTICES-1:0]),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gdfs_ram #(
    .WIDTH (VW),
    .DEPTH (VERTICES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  gdfs_seq #(
    .VERTICES (VERTICES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .err_i       (err),
    .start_i     (start_vertex_i[VW-1:0]),
    .n_i         (n_eff),
    .stk_we_o    (stk_we),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata),
    .adj_raddr_o (adj_raddr),
    .adj_rdata_i (adj_rdata),
    .busy_o      (busy),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  assign visited_vertex_o = res.vertex;
  assign status_o         = res.status;
  assign last_o           = res.last;

endmodule

`default_nettype wire

// File: rtl/core/gdfs_ram.sv
`default_nettype none

module gdfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/gdfs_seq.sv
`default_nettype none

module gdfs_seq
  import gdfs_pkg::*;
#(
  parameter int unsigned VERTICES = VERTICES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire logic                        err_i,
  input  wire logic [$clog2(VERTICES)-1:0] start_i,
  input  wire logic [CNT_W-1:0]            n_i,
  output      logic                        stk_we_o,
  output      logic [$clog2(VERTICES)-1:0] stk_waddr_o,
  output      logic [$clog2(VERTICES)-1:0] stk_wdata_o,
  output      logic [$clog2(VERTICES)-1:0] stk_raddr_o,
  input  wire logic [$clog2(VERTICES)-1:0] stk_rdata_i,
  output      logic [$clog2(VERTICES)-1:0] adj_raddr_o,
  input  wire logic [VERTICES-1:0]         adj_rdata_i,
  output      logic                        busy_o,
  output      logic                        res_valid_o,
  output      result_t                     res_o
);

  localparam int unsigned VW = $clog2(VERTICES);
  localparam logic [VW:0] SP_ONE = (VW+1)'(1);

  st_e             state_q, state_d;
  logic [VW:0]     sp_q, sp_d, sp_m1;
  logic [VW-1:0]   w_q, w_d;
  logic [VW-1:0]   v_q, v_d;
  logic [VERTICES-1:0] row_q, row_d;
  logic [VERTICES-1:0] visited_q, visited_d;
  logic            res_valid_q, res_valid_d;
  result_t         res_q, res_d;
  logic            take;

  assign sp_m1 = sp_q - SP_ONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      visited_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      visited_q   <= visited_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    v_q   <= v_d;
    row_q <= row_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    w_d         = w_q;
    v_d         = v_q;
    row_d       = row_q;
    visited_d   = visited_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    stk_we_o    = 1'b0;
    stk_waddr_o = sp_q[VW-1:0];
    stk_wdata_o = w_q;
    stk_raddr_o = sp_m1[VW-1:0];
    adj_raddr_o = stk_rdata_i;
    take        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          visited_d          = '0;
          visited_d[start_i] = 1'b1;
          stk_we_o           = 1'b1;
          stk_waddr_o        = '0;
          stk_wdata_o        = start_i;
          sp_d               = SP_ONE;
          state_d            = ST_POP;
        end else if (err_i) begin
          res_valid_d = 1'b1;
          res_d       = '{vertex: '0, status: STATUS_ERR, last: 1'b1};
        end
      end
      ST_POP: begin
        sp_d    = sp_m1;
        state_d = ST_VTX;
      end
      ST_VTX: begin
        v_d     = stk_rdata_i;
        state_d = ST_ROW;
      end
      ST_ROW: begin
        row_d   = adj_rdata_i;
        w_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // One neighbor per cycle: the row shifts down past bit 0.
        take  = row_q[0] && !visited_q[w_q];
        row_d = row_q >> 1;
        if (take) begin
          stk_we_o       = 1'b1;
          sp_d           = sp_q + SP_ONE;
          visited_d[w_q] = 1'b1;
        end
        if (CNT_W'(w_q) == n_i - CNT_W'(1)) begin
          res_valid_d = 1'b1;
          res_d       = '{vertex: VERTEX_W'(v_q), status: STATUS_OK, last: (sp_d == '0)};
          state_d     = (sp_d == '0) ? ST_IDLE : ST_POP;
        end else begin
          w_d = w_q + VW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: rtl/core/gdfs_checker.sv
`default_nettype none

module gdfs_checker
  import gdfs_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                result_valid_o,
  input wire logic [VERTEX_W-1:0] visited_vertex_o,
  input wire logic                status_o,
  input wire logic                last_o
);

  // An error result always closes its traversal and carries vertex zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == STATUS_ERR) |-> last_o && (visited_vertex_o == '0))
    else $error("error result is not a lone last result with vertex zero");

  // Busy only rises right after a start was presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // More results follow a non-final one, so the block must still be busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

  // The final result leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy)
    else $error("still busy after the final result");

endmodule

bind graph_dfs_traversal gdfs_checker u_gdfs_checker (.*);

`default_nettype wire
